// ===== sv/irpd_pkg.sv =====
// Package for the IR pulse-distance decoder: widths, phase and register codes,
// reset values of the configuration registers and the configuration struct.
// No dependencies.
package irpd_pkg;

  localparam int FRAME_W = 17;
  localparam int BIT_W   = 12;
  localparam int CNT_W   = 4;
  localparam int CMD_W   = 8;
  localparam int PHASE_W = 3;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = FRAME_W;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_LEADER  = 3'd1,
    PH_ADDRESS = 3'd2,
    PH_COMMAND = 3'd3,
    PH_END     = 3'd4
  } phase_t;

  typedef enum logic [IDX_W-1:0] {
    REG_LEADER      = 3'd0,
    REG_ADDRESS_END = 3'd1,
    REG_ZERO_SAMPLE = 3'd2,
    REG_ZERO_REWIND = 3'd3,
    REG_ONE_PERIOD  = 3'd4,
    REG_FRAME_END   = 3'd5,
    REG_BITS        = 3'd6
  } cfg_reg_t;

  localparam logic [FRAME_W-1:0] RST_LEADER      = 17'd13500;
  localparam logic [FRAME_W-1:0] RST_ADDRESS_END = 17'd40500;
  localparam logic [BIT_W-1:0]   RST_ZERO_SAMPLE = 12'd1200;
  localparam logic [BIT_W-1:0]   RST_ZERO_REWIND = 12'd1125;
  localparam logic [BIT_W-1:0]   RST_ONE_PERIOD  = 12'd2250;
  localparam logic [FRAME_W-1:0] RST_FRAME_END   = 17'd68000;
  localparam logic [CNT_W-1:0]   RST_BITS        = 4'd8;

  typedef struct packed {
    logic [FRAME_W-1:0] leader_ticks;
    logic [FRAME_W-1:0] address_end_ticks;
    logic [BIT_W-1:0]   zero_sample_ticks;
    logic [BIT_W-1:0]   zero_rewind_ticks;
    logic [BIT_W-1:0]   one_period_ticks;
    logic [FRAME_W-1:0] frame_end_ticks;
    logic [CNT_W-1:0]   bits_per_command;
  } cfg_t;

endpackage

// ===== sv/irpd_sample_if.sv =====
// Input channel of the IR pulse-distance decoder: one line sample per word.
// No dependencies.
interface irpd_sample_if;
  logic valid;
  logic ready;
  logic ir_level;

  modport source (output valid, output ir_level, input ready);
  modport sink (input valid, input ir_level, output ready);
endinterface

// ===== sv/irpd_result_if.sv =====
// Output channel of the IR pulse-distance decoder: phase and command per word.
// Depends on irpd_pkg.
interface irpd_result_if import irpd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase;
  logic [CMD_W-1:0]   command_value;
  logic               command_done;

  modport source (output valid, output phase, output command_value, output command_done,
                  input ready);
  modport sink (input valid, input phase, input command_value, input command_done,
                output ready);
endinterface

// ===== sv/irpd_cfg_if.sv =====
// Configuration write channel of the IR pulse-distance decoder.
// Depends on irpd_pkg.
interface irpd_cfg_if import irpd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/irpd_cfg_regs.sv =====
// Configuration register bank of the IR pulse-distance decoder.
// Depends on irpd_pkg and irpd_cfg_if.
module irpd_cfg_regs import irpd_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  irpd_cfg_if.sink       cfg,
  output cfg_t           regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.leader_ticks      <= RST_LEADER;
      regs.address_end_ticks <= RST_ADDRESS_END;
      regs.zero_sample_ticks <= RST_ZERO_SAMPLE;
      regs.zero_rewind_ticks <= RST_ZERO_REWIND;
      regs.one_period_ticks  <= RST_ONE_PERIOD;
      regs.frame_end_ticks   <= RST_FRAME_END;
      regs.bits_per_command  <= RST_BITS;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_LEADER:      regs.leader_ticks      <= cfg.data;
        REG_ADDRESS_END: regs.address_end_ticks <= cfg.data;
        REG_ZERO_SAMPLE: regs.zero_sample_ticks <= cfg.data[BIT_W-1:0];
        REG_ZERO_REWIND: regs.zero_rewind_ticks <= cfg.data[BIT_W-1:0];
        REG_ONE_PERIOD:  regs.one_period_ticks  <= cfg.data[BIT_W-1:0];
        REG_FRAME_END:   regs.frame_end_ticks   <= cfg.data;
        REG_BITS:        regs.bits_per_command  <= cfg.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/irpd_core.sv =====
// Frame state machine, timers and command shift register of the IR decoder,
// with the result register on the output channel.
// Depends on irpd_pkg, irpd_sample_if and irpd_result_if.
module irpd_core import irpd_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           regs,
  irpd_sample_if.sink    samples,
  irpd_result_if.source  results
);

  phase_t             phase_reg, phase_next;
  logic [FRAME_W-1:0] frame_timer, frame_timer_next;
  logic [BIT_W-1:0]   bit_timer, bit_timer_next;
  logic [CNT_W-1:0]   bit_count, bit_count_next;
  logic [CMD_W-1:0]   shift_value, shift_value_next;
  logic               done_next;

  logic               out_valid;
  phase_t             out_phase;
  logic [CMD_W-1:0]   out_command;
  logic               out_done;

  logic               take;
  logic               line_low;
  logic [FRAME_W-1:0] frame_inc;
  logic [BIT_W-1:0]   bit_inc;
  logic               zero_hit;
  logic               one_hit;
  logic               count_full;

  assign samples.ready = !out_valid || results.ready;
  assign take          = samples.valid && samples.ready;
  assign line_low      = !samples.ir_level;
  assign frame_inc     = frame_timer + 1'b1;
  assign bit_inc       = bit_timer + 1'b1;
  assign zero_hit      = (bit_inc == regs.zero_sample_ticks) && line_low;
  assign one_hit       = !zero_hit && (bit_inc == regs.one_period_ticks);
  assign count_full    = (bit_count == regs.bits_per_command);

  always_comb begin
    phase_next = phase_reg;
    unique case (phase_reg)
      PH_IDLE:    if (line_low) phase_next = PH_LEADER;
      PH_LEADER:  if (frame_inc == regs.leader_ticks) phase_next = PH_ADDRESS;
      PH_ADDRESS: if (frame_inc == regs.address_end_ticks) phase_next = PH_COMMAND;
      PH_COMMAND: if (count_full) phase_next = PH_END;
      PH_END:     if (frame_inc > regs.frame_end_ticks) phase_next = PH_IDLE;
      default:    phase_next = phase_reg;
    endcase
  end

  always_comb begin
    frame_timer_next = frame_timer;
    bit_timer_next   = bit_timer;
    bit_count_next   = bit_count;
    shift_value_next = shift_value;
    done_next        = 1'b0;
    unique case (phase_reg)
      PH_LEADER, PH_ADDRESS: frame_timer_next = frame_inc;
      PH_COMMAND: begin
        frame_timer_next = frame_inc;
        bit_timer_next   = bit_inc;
        done_next        = count_full;
        if (zero_hit) begin
          bit_timer_next   = bit_inc - regs.zero_rewind_ticks;
          shift_value_next = {shift_value[CMD_W-2:0], 1'b0};
          bit_count_next   = bit_count + 1'b1;
        end else if (one_hit) begin
          bit_timer_next   = '0;
          shift_value_next = {shift_value[CMD_W-2:0], 1'b1};
          bit_count_next   = bit_count + 1'b1;
        end
      end
      PH_END: begin
        frame_timer_next = frame_inc;
        if (frame_inc > regs.frame_end_ticks) begin
          frame_timer_next = '0;
          bit_timer_next   = '0;
          bit_count_next   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= PH_IDLE;
      frame_timer <= '0;
      bit_timer   <= '0;
      bit_count   <= '0;
      shift_value <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        phase_reg   <= phase_next;
        frame_timer <= frame_timer_next;
        bit_timer   <= bit_timer_next;
        bit_count   <= bit_count_next;
        shift_value <= shift_value_next;
        out_valid   <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_phase   <= phase_next;
      out_command <= shift_value_next;
      out_done    <= done_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.phase         = out_phase;
  assign results.command_value = out_command;
  assign results.command_done  = out_done;

endmodule

// ===== sv/ir_pulse_distance_decoder.sv =====
// IR pulse-distance decoder: takes one active-low receiver sample per input word
// and returns one word per sample with the frame phase, the command shift register
// and a flag on the tick the command phase ends. The block accepts a sample in every
// cycle except when a result waits and the sink does not take it in that cycle; the
// result word for a sample appears in the cycle after it is accepted, set by the
// single state-update stage feeding the result register. The user must write the
// timing registers over the configuration channel only with the block idle; the
// block itself does not enforce this. Depends on irpd_pkg, the three channel
// interfaces, irpd_cfg_regs and irpd_core.
module ir_pulse_distance_decoder import irpd_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  irpd_cfg_if.sink       cfg,
  irpd_sample_if.sink    samples,
  irpd_result_if.source  results
);

  cfg_t regs;

  irpd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  irpd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs),
    .samples (samples),
    .results (results)
  );

endmodule

// ===== sv/irpd_checker.sv =====
// Port-level checks for the IR pulse-distance decoder, bound to the top level.
// Depends on irpd_pkg and ir_pulse_distance_decoder.
module irpd_checker import irpd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PHASE_W-1:0] out_phase,
  input logic [CMD_W-1:0]   out_command,
  input logic               out_done
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_phase) &&
      $stable(out_command) && $stable(out_done))
    else $error("result word changed while stalled");

  a_done_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_done |-> out_phase == PH_END)
    else $error("command done flagged outside the end phase");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted sample produced no result word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word pending after reset");

endmodule

bind ir_pulse_distance_decoder irpd_checker u_irpd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_phase   (results.phase),
  .out_command (results.command_value),
  .out_done    (results.command_done)
);
